>>> rtl/fma_pkg.sv
// shared widths, request codes and item types for the four-momentum accumulator
`timescale 1ns / 1ps
package fma_pkg;

  localparam int COMP_BITS = 24;
  localparam int CW1       = COMP_BITS + 1;
  localparam int ROOT_W    = COMP_BITS + 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SUM_W     = RAD_W + 1;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_SUB  = 2'd2
  } req_code_t;

  typedef struct packed {
    logic [1:0]                  req_type;
    logic signed [COMP_BITS-1:0] in_px;
    logic signed [COMP_BITS-1:0] in_py;
    logic signed [COMP_BITS-1:0] in_pz;
    logic [COMP_BITS-2:0]        in_mass;
  } req_t;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] out_px;
    logic signed [COMP_BITS-1:0] out_py;
    logic signed [COMP_BITS-1:0] out_pz;
    logic [COMP_BITS-1:0]        out_mass;
    logic [COMP_BITS-1:0]        out_energy;
    logic                        saturated;
  } rsp_t;

endpackage

>>> rtl/fma_isqrt.sv
// bit-serial truncating integer square root, one result bit per cycle
`timescale 1ns / 1ps
module fma_isqrt import fma_pkg::*; #(
  parameter int RW = RAD_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RW-1:0]     rad_in,
  output logic              done,
  output logic [RW/2-1:0]   root
);

  localparam int QW    = RW / 2;
  localparam int REM_W = QW + 2;
  localparam int CNT_W = $clog2(QW + 1);

  logic [RW-1:0]      rad;
  logic [REM_W-1:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               take;

  // next two radicand bits appended to the remainder, trial is 4*root + 1
  assign rem_sh = {rem, rad[RW-1:RW-2]};
  assign trial  = {{(REM_W-QW){1'b0}}, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RW-3:0], 2'b00};
      if (take) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[QW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[QW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/four_momentum_accumulator.sv
// four-momentum accumulator: sequencer, squaring unit and accumulator state
//
// request channel (req_valid / req_ready / req) carries one item: a request code
// and an operand vector. load sets the accumulator, add combines the two
// four-vectors and recomputes the invariant mass, subtract changes only the
// momentum. every item gives exactly one result item on the response channel
// (rsp_valid / rsp_ready / rsp): the accumulator after the step, its energy and
// a flag for clipped components or mass. an unused code returns the state as is.
// one item is worked on at a time and req_ready is low until it is finished.
// each energy or mass is a pass of four squarings on one shared multiplier,
// then a square root on one shared unit that gives one bit a cycle.
// load and subtract take one pass, add takes four; an add whose mass radicand
// is not positive skips the square root of its mass pass.
// the result sits in an output register: a new item is accepted while it waits,
// and if the receiver stalls the next result is held until the register frees.
// reset (rst, synchronous) clears the accumulator to zero and drops rsp_valid.
`timescale 1ns / 1ps
module four_momentum_accumulator import fma_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_START = 6'b001000,
    ST_ROOT  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PH_EO   = 2'd0,
    PH_EM   = 2'd1,
    PH_MASS = 2'd2,
    PH_EN   = 2'd3
  } phase_t;

  state_t state;
  phase_t phase;
  logic [1:0] k;

  logic signed [COMP_BITS-1:0] acc_px, acc_py, acc_pz;
  logic [COMP_BITS-1:0]        acc_mass;
  logic signed [COMP_BITS-1:0] op_px, op_py, op_pz;
  logic [COMP_BITS-2:0]        op_mass;
  logic [ROOT_W-1:0]           eo;
  logic [ROOT_W-1:0]           es;
  logic [COMP_BITS-1:0]        energy;
  logic                        sat;

  logic [ROOT_W-1:0]           mul_a;
  logic [RAD_W-1:0]            prod;
  logic signed [SUM_W-1:0]     prod_s;
  logic signed [SUM_W-1:0]     sum;
  logic                        sum_pos;
  logic                        sq_start;
  logic                        sq_done;
  logic [ROOT_W-1:0]           sq_root;
  logic                        fin;
  logic [ROOT_W-1:0]           fin_root;
  logic                        root_big;
  logic                        accept;
  logic [CW1-1:0]              nx, ny, nz;
  logic [CW1-1:0]              dx, dy, dz;
  logic                        do_sub;

  function automatic logic [ROOT_W-1:0] abs_c(input logic signed [COMP_BITS-1:0] v);
    logic signed [ROOT_W-1:0] e;
    e = ROOT_W'(v);
    return (e < 0) ? ROOT_W'($unsigned(-e)) : ROOT_W'($unsigned(e));
  endfunction

  // returns {clipped, value}
  function automatic logic [CW1-1:0] sat_add(input logic signed [COMP_BITS-1:0] a,
                                            input logic signed [COMP_BITS-1:0] b,
                                            input logic sub);
    logic signed [CW1-1:0] s;
    logic [CW1-1:0] r;
    s = sub ? (CW1'(a) - CW1'(b)) : (CW1'(a) + CW1'(b));
    if (s[COMP_BITS] != s[COMP_BITS-1]) begin
      r = s[COMP_BITS] ? {1'b1, 1'b1, {(COMP_BITS-1){1'b0}}}
                       : {1'b1, 1'b0, {(COMP_BITS-1){1'b1}}};
    end else begin
      r = {1'b0, s[COMP_BITS-1:0]};
    end
    return r;
  endfunction

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign prod_s    = $signed({1'b0, prod});
  assign sum_pos   = (sum > 0);

  // operand for the shared squarer, chosen by pass and term
  always_comb begin
    mul_a = '0;
    case (phase)
      PH_EO: begin
        case (k)
          2'd0:    mul_a = abs_c(op_px);
          2'd1:    mul_a = abs_c(op_py);
          2'd2:    mul_a = abs_c(op_pz);
          default: mul_a = ROOT_W'(op_mass);
        endcase
      end
      PH_MASS: begin
        case (k)
          2'd0:    mul_a = es;
          2'd1:    mul_a = abs_c(acc_px);
          2'd2:    mul_a = abs_c(acc_py);
          default: mul_a = abs_c(acc_pz);
        endcase
      end
      default: begin
        case (k)
          2'd0:    mul_a = abs_c(acc_px);
          2'd1:    mul_a = abs_c(acc_py);
          2'd2:    mul_a = abs_c(acc_pz);
          default: mul_a = ROOT_W'(acc_mass);
        endcase
      end
    endcase
  end

  // mass pass subtracts the new |p|^2 from the squared energy sum
  assign do_sub = (phase == PH_MASS) && (k != 2'd0);

  // a pass ends with the root, or with zero when the mass radicand is not positive
  always_comb begin
    sq_start = (state == ST_START) && !((phase == PH_MASS) && !sum_pos);
    fin      = ((state == ST_ROOT) && sq_done) ||
               ((state == ST_START) && (phase == PH_MASS) && !sum_pos);
    fin_root = (state == ST_ROOT) ? sq_root : '0;
    root_big = |fin_root[ROOT_W-1:COMP_BITS];
  end

  assign nx = sat_add(acc_px, op_px, 1'b0);
  assign ny = sat_add(acc_py, op_py, 1'b0);
  assign nz = sat_add(acc_pz, op_pz, 1'b0);

  assign dx = sat_add(acc_px, req.in_px, 1'b1);
  assign dy = sat_add(acc_py, req.in_py, 1'b1);
  assign dz = sat_add(acc_pz, req.in_pz, 1'b1);

  fma_isqrt #(
    .RW (RAD_W)
  ) u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .rad_in (sum[RAD_W-1:0]),
    .done   (sq_done),
    .root   (sq_root)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_EN;
      k         <= '0;
      acc_px    <= '0;
      acc_py    <= '0;
      acc_pz    <= '0;
      acc_mass  <= '0;
      rsp_valid <= 1'b0;
      sat       <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != ST_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_px   <= req.in_px;
            op_py   <= req.in_py;
            op_pz   <= req.in_pz;
            op_mass <= req.in_mass;
            k       <= '0;
            sum     <= '0;
            sat     <= (req.req_type == REQ_SUB) &&
                       (dx[COMP_BITS] | dy[COMP_BITS] | dz[COMP_BITS]);
            state   <= ST_MUL;
            phase   <= (req.req_type == REQ_ADD) ? PH_EO : PH_EN;
            case (req.req_type)
              REQ_LOAD: begin
                acc_px   <= req.in_px;
                acc_py   <= req.in_py;
                acc_pz   <= req.in_pz;
                acc_mass <= {1'b0, req.in_mass};
              end
              REQ_SUB: begin
                acc_px <= dx[COMP_BITS-1:0];
                acc_py <= dy[COMP_BITS-1:0];
                acc_pz <= dz[COMP_BITS-1:0];
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum <= do_sub ? (sum - prod_s) : (sum + prod_s);
          k   <= k + 2'd1;
          state <= (k == 2'd3) ? ST_START : ST_MUL;
        end
        ST_START: begin
          if (!fin) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
        end
        ST_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.out_px     <= acc_px;
            rsp.out_py     <= acc_py;
            rsp.out_pz     <= acc_pz;
            rsp.out_mass   <= acc_mass;
            rsp.out_energy <= energy;
            rsp.saturated  <= sat;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (fin) begin
        k     <= '0;
        sum   <= '0;
        state <= (phase == PH_EN) ? ST_FIN : ST_MUL;
        case (phase)
          PH_EO: begin
            eo    <= fin_root;
            phase <= PH_EM;
          end
          PH_EM: begin
            // energies use the old state, the momentum is updated only now
            es     <= ROOT_W'(eo + fin_root);
            acc_px <= nx[COMP_BITS-1:0];
            acc_py <= ny[COMP_BITS-1:0];
            acc_pz <= nz[COMP_BITS-1:0];
            sat    <= sat | nx[COMP_BITS] | ny[COMP_BITS] | nz[COMP_BITS];
            phase  <= PH_MASS;
          end
          PH_MASS: begin
            if (root_big) begin
              acc_mass <= '1;
              sat      <= 1'b1;
            end else begin
              acc_mass <= fin_root[COMP_BITS-1:0];
            end
            phase <= PH_EN;
          end
          default: begin
            energy <= root_big ? '1 : fin_root[COMP_BITS-1:0];
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/fma_checker.sv
// port-level checks for the four-momentum accumulator, bound to the top level
`timescale 1ns / 1ps
module fma_checker import fma_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // a waiting result is held
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted an item while one is in work");

  // reset leaves no result offered
  a_reset: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result offered straight after reset");

  // energy never falls below the mass
  a_energy_ge_mass: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.out_energy >= rsp.out_mass)
    else $error("energy below mass");

  // a null vector has no energy
  a_null: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_px == 0 && rsp.out_py == 0 && rsp.out_pz == 0 &&
    rsp.out_mass == 0 |-> rsp.out_energy == 0)
    else $error("null vector with energy");

endmodule

bind four_momentum_accumulator fma_checker u_fma_checker (.*);

>>> tb/tb_four_momentum_accumulator.sv
// self-checking testbench for the four-momentum accumulator, with its own four-vector predictor
`timescale 1ns / 1ps
module tb_four_momentum_accumulator;
  import fma_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [COMP_BITS-1:0] COMP_MAX  = {1'b0, {(COMP_BITS-1){1'b1}}};
  localparam logic [COMP_BITS-1:0] COMP_MIN  = {1'b1, {(COMP_BITS-1){1'b0}}};
  localparam logic [COMP_BITS-2:0] MASS_MAX  = {(COMP_BITS-1){1'b1}};
  localparam longint unsigned      WIDE_MAX  = (64'd1 << COMP_BITS) - 1;
  localparam int                   DRAIN_CYC = 200;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // predictor state
  logic signed [COMP_BITS-1:0] mom_x, mom_y, mom_z;
  logic [COMP_BITS-1:0]        mom_mass;

  rsp_t expected_vectors[$];
  int   mismatch_count;
  bit   idle_on;
  int   long_hold;

  four_momentum_accumulator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint widen(logic [COMP_BITS-1:0] v);
    return {{(64-COMP_BITS){v[COMP_BITS-1]}}, v};
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned momentum_sq(longint x, longint y, longint z);
    return longint'(x * x) + longint'(y * y) + longint'(z * z);
  endfunction

  function automatic longint unsigned energy_of(longint x, longint y, longint z,
                                                longint unsigned m);
    return int_sqrt(m * m + momentum_sq(x, y, z));
  endfunction

  function automatic logic [COMP_BITS-1:0] clip_comp(longint x, inout bit clipped);
    longint hi, lo;
    hi = (longint'(1) <<< (COMP_BITS-1)) - 1;
    lo = -(longint'(1) <<< (COMP_BITS-1));
    if (x > hi) begin
      clipped = 1'b1;
      return COMP_MAX;
    end
    if (x < lo) begin
      clipped = 1'b1;
      return COMP_MIN;
    end
    return x[COMP_BITS-1:0];
  endfunction

  // steps the predicted accumulator by one item and returns the result it should report
  function automatic rsp_t advance_four_vector(req_t item);
    longint          ox, oy, oz, ax, ay, az;
    longint unsigned om, e_op, e_acc, e_sum, p2, new_mass, e;
    bit              clipped;
    rsp_t            r;
    clipped = 1'b0;
    ox = widen(item.in_px);
    oy = widen(item.in_py);
    oz = widen(item.in_pz);
    om = 64'(item.in_mass);
    ax = widen(mom_x);
    ay = widen(mom_y);
    az = widen(mom_z);
    case (item.req_type)
      REQ_LOAD: begin
        mom_x    = item.in_px;
        mom_y    = item.in_py;
        mom_z    = item.in_pz;
        mom_mass = {1'b0, item.in_mass};
      end
      REQ_ADD: begin
        // both energies from the values before clipping
        e_op  = energy_of(ox, oy, oz, om);
        e_acc = energy_of(ax, ay, az, 64'(mom_mass));
        mom_x = clip_comp(ax + ox, clipped);
        mom_y = clip_comp(ay + oy, clipped);
        mom_z = clip_comp(az + oz, clipped);
        e_sum = e_op + e_acc;
        p2    = momentum_sq(widen(mom_x), widen(mom_y), widen(mom_z));
        new_mass = (e_sum * e_sum > p2) ? int_sqrt(e_sum * e_sum - p2) : 64'd0;
        if (new_mass > WIDE_MAX) begin
          new_mass = WIDE_MAX;
          clipped  = 1'b1;
        end
        mom_mass = new_mass[COMP_BITS-1:0];
      end
      REQ_SUB: begin
        mom_x = clip_comp(ax - ox, clipped);
        mom_y = clip_comp(ay - oy, clipped);
        mom_z = clip_comp(az - oz, clipped);
      end
      default: ;
    endcase
    e = energy_of(widen(mom_x), widen(mom_y), widen(mom_z), 64'(mom_mass));
    if (e > WIDE_MAX) e = WIDE_MAX;
    r.out_px     = mom_x;
    r.out_py     = mom_y;
    r.out_pz     = mom_z;
    r.out_mass   = mom_mass;
    r.out_energy = e[COMP_BITS-1:0];
    r.saturated  = clipped;
    return r;
  endfunction

  function automatic req_t make_item(logic [1:0] code, logic [COMP_BITS-1:0] x,
                                     logic [COMP_BITS-1:0] y, logic [COMP_BITS-1:0] z,
                                     logic [COMP_BITS-2:0] m);
    req_t item;
    item.req_type = code;
    item.in_px    = x;
    item.in_py    = y;
    item.in_pz    = z;
    item.in_mass  = m;
    return item;
  endfunction

  function automatic logic [COMP_BITS-1:0] pick_comp();
    logic [COMP_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = COMP_MAX;
      1:       v = COMP_MIN;
      2:       v = '0;
      3, 4:    v = COMP_BITS'($urandom_range(0, 2000) - 1000);
      5:       v = COMP_BITS'($urandom_range(0, 200000) - 100000);
      default: v = COMP_BITS'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [COMP_BITS-2:0] pick_mass();
    logic [COMP_BITS-2:0] v;
    case ($urandom_range(0, 7))
      0:       v = MASS_MAX;
      1:       v = '0;
      2, 3:    v = (COMP_BITS-1)'($urandom_range(0, 1000));
      default: v = (COMP_BITS-1)'($urandom);
    endcase
    return v;
  endfunction

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_item(req_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    expected_vectors.push_back(advance_four_vector(item));
  endtask

  task automatic report_field(string name, logic [COMP_BITS-1:0] want,
                              logic [COMP_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_vectors.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual %h", $time, rsp);
        mismatch_count++;
      end else begin
        want = expected_vectors.pop_front();
        report_field("out_px", want.out_px, rsp.out_px);
        report_field("out_py", want.out_py, rsp.out_py);
        report_field("out_pz", want.out_pz, rsp.out_pz);
        report_field("out_mass", want.out_mass, rsp.out_mass);
        report_field("out_energy", want.out_energy, rsp.out_energy);
        report_field("saturated", {23'd0, want.saturated}, {23'd0, rsp.saturated});
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        rsp_ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
        rsp_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic test_unused_code();
    send_item(make_item(REQ_NONE, pick_comp(), pick_comp(), pick_comp(), pick_mass()));
  endtask

  task automatic test_load_extremes();
    send_item(make_item(REQ_LOAD, COMP_MAX, COMP_MAX, COMP_MAX, MASS_MAX));
    send_item(make_item(REQ_NONE, COMP_MIN, COMP_MAX, '0, '0));
    send_item(make_item(REQ_LOAD, COMP_MIN, COMP_MIN, COMP_MIN, '0));
    send_item(make_item(REQ_LOAD, '0, '0, '0, '0));
  endtask

  task automatic test_add();
    send_item(make_item(REQ_ADD, '0, '0, '0, '0));
    send_item(make_item(REQ_ADD, 24'd3, 24'd4, 24'd0, 23'd5));
    send_item(make_item(REQ_ADD, -24'sd3, -24'sd4, 24'd0, 23'd5));
    send_item(make_item(REQ_ADD, 24'd1000, -24'sd2000, 24'd300, 23'd12345));
    // component clipping, energies taken before the clip
    send_item(make_item(REQ_LOAD, COMP_MAX, COMP_MIN, 24'd7, 23'd100));
    send_item(make_item(REQ_ADD, COMP_MAX, COMP_MIN, 24'd7, 23'd100));
  endtask

  task automatic test_mass_and_energy_clip();
    // back-to-back heavy vectors push the mass past its range
    send_item(make_item(REQ_LOAD, COMP_MAX, '0, '0, MASS_MAX));
    send_item(make_item(REQ_ADD, COMP_MIN, '0, '0, MASS_MAX));
    // large momentum on top of a full mass overflows the energy only
    send_item(make_item(REQ_SUB, COMP_MIN, '0, '0, MASS_MAX));
    send_item(make_item(REQ_SUB, COMP_MIN, COMP_MAX, COMP_MIN, '0));
  endtask

  task automatic test_subtract();
    send_item(make_item(REQ_LOAD, COMP_MIN, 24'd10, COMP_MAX, 23'd77));
    send_item(make_item(REQ_SUB, COMP_MAX, COMP_MIN, -24'sd1, MASS_MAX));
    send_item(make_item(REQ_SUB, 24'd1, -24'sd1, 24'd0, 23'd0));
    send_item(make_item(REQ_SUB, '0, '0, '0, MASS_MAX));
    test_unused_code();
  endtask

  task automatic send_random_item();
    logic [1:0] code;
    int         sel;
    sel = $urandom_range(0, 99);
    if (sel < 20)      code = REQ_LOAD;
    else if (sel < 60) code = REQ_ADD;
    else if (sel < 92) code = REQ_SUB;
    else               code = REQ_NONE;
    send_item(make_item(code, pick_comp(), pick_comp(), pick_comp(), pick_mass()));
  endtask

  task automatic test_backpressure();
    long_hold = 1000;
    repeat (8) send_random_item();
  endtask

  task automatic test_random(int count);
    repeat (count) send_random_item();
  endtask

  task automatic test_steady_stream(int count);
    idle_on = 1'b0;
    repeat (count) send_random_item();
  endtask

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    mom_x          = '0;
    mom_y          = '0;
    mom_z          = '0;
    mom_mass       = '0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    long_hold      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_unused_code();
    test_load_extremes();
    test_add();
    test_mass_and_energy_clip();
    test_subtract();
    test_backpressure();
    test_random(1300);
    test_steady_stream(170);
    req_valid <= 1'b0;

    while (expected_vectors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
